// ----- rtl/sfcr_pkg.sv -----
`default_nettype none

package sfcr_pkg;

  // phase codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_TRANS = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

  // configuration port geometry
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // register indexes (byte address is four times the index)
  localparam logic [2:0] REG_START_EDGE_LIMIT    = 3'd0;
  localparam logic [2:0] REG_INITIAL_HALF_PERIOD = 3'd1;
  localparam logic [2:0] REG_MIN_HALF_PERIOD     = 3'd2;
  localparam logic [2:0] REG_RAMP_STEP           = 3'd3;
  localparam logic [2:0] REG_PERIODS_PER_STEP    = 3'd4;

  // reset values of the registers
  localparam logic [15:0] START_EDGE_LIMIT_RST    = 16'd4000;
  localparam logic [15:0] INITIAL_HALF_PERIOD_RST = 16'd8267;
  localparam logic [15:0] MIN_HALF_PERIOD_RST     = 16'd6000;
  localparam logic [7:0]  RAMP_STEP_RST           = 8'd5;
  localparam logic [9:0]  PERIODS_PER_STEP_RST    = 10'd200;

  // saturation limits
  localparam logic [15:0] EDGE_COUNT_MAX   = 16'hFFFF;
  localparam logic [9:0]  PERIOD_COUNT_MAX = 10'h3FF;

  typedef struct packed {
    logic [15:0] start_edge_limit;
    logic [15:0] initial_half_period;
    logic [15:0] min_half_period;
    logic [7:0]  ramp_step;
    logic [9:0]  periods_per_step;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/sfcr_if.sv -----
`default_nettype none

// hall sample channel
interface sfcr_in_if;
  logic valid;
  logic ready;
  logic hall_level;

  modport source (output valid, output hall_level, input ready);
  modport sink (input valid, input hall_level, output ready);
endinterface

// gate drive channel
interface sfcr_out_if;
  logic       valid;
  logic       ready;
  logic       gate_high_one;
  logic       gate_low_one;
  logic       gate_high_two;
  logic       gate_low_two;
  logic [1:0] phase_now;

  modport source (
    output valid, output gate_high_one, output gate_low_one,
    output gate_high_two, output gate_low_two, output phase_now,
    input ready
  );
  modport sink (
    input valid, input gate_high_one, input gate_low_one,
    input gate_high_two, input gate_low_two, input phase_now,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/single_phase_fan_commutation_ramp.sv -----
// Single-phase fan commutation with open-loop speed ramp.
//
// samples (sink): one item per timer tick, carrying the hall sensor level.
// drive (source): one item per input item, the four bridge gate levels
//   and the phase of that tick (0 start, 1 transition, 2 run).
// APB port: five registers at byte addresses 0, 4, 8, 12, 16; pready is
//   always high, writes land on the access cycle, reads return the value.
//
// An accepted item is shown on drive in the cycle after it is accepted.
// Throughput is one item per cycle unless drive stalls; the whole update
// of one tick is a single pass between the state registers and the result
// register, so a tick can be taken on every clock that is not stalled.
// When the receiver stalls, the result register holds its item and
// samples.ready drops until it is taken; a new item is accepted in the
// same cycle as the waiting one leaves.
// Synchronous reset puts the block in the start phase with drive_pattern low,
// clears all counters, loads the register defaults and empties the result
// register; no item is accepted while rst is high.
`default_nettype none

module single_phase_fan_commutation_ramp import sfcr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  sfcr_in_if.sink                samples,
  sfcr_out_if.source             drive,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  cfg_t cfg;

  sfcr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // state registers
  logic [1:0]  phase_reg, phase_next;
  logic [15:0] edge_count, edge_count_next;
  logic        previous_hall;
  logic        hall_seen;
  logic        drive_pattern, drive_pattern_next;
  logic [15:0] half_period, half_period_next;
  logic [15:0] half_timer, half_timer_next;
  logic        second_half, second_half_next;
  logic [9:0]  period_count, period_count_next;

  // result register
  logic       out_valid;
  logic       out_pattern;
  logic [1:0] out_phase;
  logic [1:0] shown;

  logic        accept;
  logic [15:0] edge_inc;
  logic [15:0] hp_ramp;
  logic [9:0]  pc_ramp;
  logic [15:0] timer_inc;
  logic        hall;

  assign hall          = samples.hall_level;
  assign samples.ready = !rst && (!out_valid || drive.ready);
  assign accept        = samples.valid && samples.ready;

  // next state for one tick
  always_comb begin
    phase_next         = phase_reg;
    edge_count_next    = edge_count;
    drive_pattern_next = drive_pattern;
    half_period_next   = half_period;
    half_timer_next    = half_timer;
    second_half_next   = second_half;
    period_count_next  = period_count;
    shown              = phase_reg;
    edge_inc           = edge_count;
    hp_ramp            = half_period;
    pc_ramp            = period_count;
    timer_inc          = half_timer + 16'd1;

    unique case (phase_reg)
      PH_RUN: begin
        // ramp step at the start of a period once enough periods have gone
        if (half_timer == 16'd0 && !second_half && period_count > cfg.periods_per_step) begin
          if (half_period > cfg.min_half_period) begin
            hp_ramp = (half_period > {8'd0, cfg.ramp_step}) ?
                      half_period - {8'd0, cfg.ramp_step} : 16'd0;
          end
          pc_ramp = '0;
        end
        half_period_next = hp_ramp;
        // half period expiry toggles the drive
        if (timer_inc >= hp_ramp) begin
          half_timer_next    = '0;
          drive_pattern_next = !drive_pattern;
          second_half_next   = !second_half;
          period_count_next  = (second_half && pc_ramp != PERIOD_COUNT_MAX) ?
                               pc_ramp + 10'd1 : pc_ramp;
        end else begin
          half_timer_next   = timer_inc;
          period_count_next = pc_ramp;
        end
      end
      PH_TRANS: begin
        drive_pattern_next = hall;
        half_period_next   = cfg.initial_half_period;
        half_timer_next    = '0;
        second_half_next   = 1'b0;
        period_count_next  = '0;
        phase_next         = PH_RUN;
      end
      default: begin
        // start phase, the unused code behaves the same
        shown              = PH_START;
        drive_pattern_next = hall;
        if (hall_seen && hall != previous_hall && edge_count != EDGE_COUNT_MAX) begin
          edge_inc = edge_count + 16'd1;
        end
        if (edge_inc > cfg.start_edge_limit) begin
          phase_next      = PH_TRANS;
          edge_count_next = '0;
        end else begin
          phase_next      = PH_START;
          edge_count_next = edge_inc;
        end
      end
    endcase
  end

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_START;
      edge_count    <= '0;
      previous_hall <= 1'b0;
      hall_seen     <= 1'b0;
      drive_pattern <= 1'b0;
      half_period   <= INITIAL_HALF_PERIOD_RST;
      half_timer    <= '0;
      second_half   <= 1'b0;
      period_count  <= '0;
    end else if (accept) begin
      phase_reg     <= phase_next;
      edge_count    <= edge_count_next;
      previous_hall <= hall;
      hall_seen     <= 1'b1;
      drive_pattern <= drive_pattern_next;
      half_period   <= half_period_next;
      half_timer    <= half_timer_next;
      second_half   <= second_half_next;
      period_count  <= period_count_next;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (drive.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_pattern <= drive_pattern_next;
      out_phase   <= shown;
    end
  end

  assign drive.valid         = out_valid;
  assign drive.gate_high_one = out_pattern;
  assign drive.gate_low_one  = !out_pattern;
  assign drive.gate_high_two = !out_pattern;
  assign drive.gate_low_two  = out_pattern;
  assign drive.phase_now     = out_phase;

endmodule

`default_nettype wire

// ----- rtl/sfcr_regs.sv -----
`default_nettype none

module sfcr_regs import sfcr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output cfg_t                   cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_edge_limit    <= START_EDGE_LIMIT_RST;
      cfg.initial_half_period <= INITIAL_HALF_PERIOD_RST;
      cfg.min_half_period     <= MIN_HALF_PERIOD_RST;
      cfg.ramp_step           <= RAMP_STEP_RST;
      cfg.periods_per_step    <= PERIODS_PER_STEP_RST;
    end else if (wr_en) begin
      unique case (index)
        REG_START_EDGE_LIMIT:    cfg.start_edge_limit    <= pwdata[15:0];
        REG_INITIAL_HALF_PERIOD: cfg.initial_half_period <= pwdata[15:0];
        REG_MIN_HALF_PERIOD:     cfg.min_half_period     <= pwdata[15:0];
        REG_RAMP_STEP:           cfg.ramp_step           <= pwdata[7:0];
        REG_PERIODS_PER_STEP:    cfg.periods_per_step    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (index)
      REG_START_EDGE_LIMIT:    prdata = {16'd0, cfg.start_edge_limit};
      REG_INITIAL_HALF_PERIOD: prdata = {16'd0, cfg.initial_half_period};
      REG_MIN_HALF_PERIOD:     prdata = {16'd0, cfg.min_half_period};
      REG_RAMP_STEP:           prdata = {24'd0, cfg.ramp_step};
      REG_PERIODS_PER_STEP:    prdata = {22'd0, cfg.periods_per_step};
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sfcr_checker.sv -----
`default_nettype none

module sfcr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       gate_high_one,
  input wire logic       gate_low_one,
  input wire logic       gate_high_two,
  input wire logic       gate_low_two,
  input wire logic [1:0] phase_now
);

  // a waiting item stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phase_now) && $stable(gate_high_one))
    else $error("result item changed while stalled");

  // the bridge never shorts a leg and the diagonals agree
  a_gates: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gate_high_one == gate_low_two && gate_low_one == gate_high_two &&
                  gate_high_one != gate_low_one)
    else $error("gate levels inconsistent");

  // an accepted item is shown on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // an empty result register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

endmodule

bind single_phase_fan_commutation_ramp sfcr_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .out_valid     (drive.valid),
  .out_ready     (drive.ready),
  .gate_high_one (drive.gate_high_one),
  .gate_low_one  (drive.gate_low_one),
  .gate_high_two (drive.gate_high_two),
  .gate_low_two  (drive.gate_low_two),
  .phase_now     (drive.phase_now)
);

`default_nettype wire

// ----- test/sfcr_commutation_checker.sv -----
`default_nettype none

module sfcr_commutation_checker
  import sfcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  sfcr_in_if                samples,
  sfcr_out_if               drive,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mismatches,
  output int                outstanding,
  output int                results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       gate_high_one;
    logic       gate_low_one;
    logic       gate_high_two;
    logic       gate_low_two;
    logic [1:0] phase_now;
  } gate_item_t;

  // shadow of the register file and of the commutation state
  cfg_t        regs;
  logic [1:0]  phase;
  logic [15:0] edge_count;
  logic        prev_hall;
  logic        hall_seen;
  logic        pattern_a;
  logic [15:0] half_period;
  logic [15:0] half_timer;
  logic        second_half;
  logic [9:0]  period_count;

  // gate items still owed by the block, oldest first
  gate_item_t gate_queue[$];

  function automatic void clear_state();
    regs.start_edge_limit    = START_EDGE_LIMIT_RST;
    regs.initial_half_period = INITIAL_HALF_PERIOD_RST;
    regs.min_half_period     = MIN_HALF_PERIOD_RST;
    regs.ramp_step           = RAMP_STEP_RST;
    regs.periods_per_step    = PERIODS_PER_STEP_RST;
    phase        = PH_START;
    edge_count   = '0;
    prev_hall    = 1'b0;
    hall_seen    = 1'b0;
    pattern_a    = 1'b0;
    half_period  = INITIAL_HALF_PERIOD_RST;
    half_timer   = '0;
    second_half  = 1'b0;
    period_count = '0;
    gate_queue.delete();
  endfunction

  function automatic void load_register(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    case (idx)
      REG_START_EDGE_LIMIT:    regs.start_edge_limit    = value[15:0];
      REG_INITIAL_HALF_PERIOD: regs.initial_half_period = value[15:0];
      REG_MIN_HALF_PERIOD:     regs.min_half_period     = value[15:0];
      REG_RAMP_STEP:           regs.ramp_step           = value[7:0];
      REG_PERIODS_PER_STEP:    regs.periods_per_step    = value[9:0];
      default: ;
    endcase
  endfunction

  // one timer tick: advance the shadow state and return the gate item it shows
  function automatic gate_item_t commutate_tick(input logic hall);
    logic [1:0] shown;
    gate_item_t item;
    shown = phase;
    if (phase == PH_RUN) begin
      // ramp step at the start of a period once enough periods have passed
      if (half_timer == 16'd0 && !second_half && period_count > regs.periods_per_step) begin
        if (half_period > regs.min_half_period)
          half_period = (half_period > 16'(regs.ramp_step)) ?
                        half_period - 16'(regs.ramp_step) : 16'd0;
        period_count = '0;
      end
      half_timer = half_timer + 16'd1;
      if (half_timer >= half_period) begin
        half_timer = '0;
        pattern_a  = ~pattern_a;
        if (second_half && period_count < PERIOD_COUNT_MAX)
          period_count = period_count + 10'd1;
        second_half = ~second_half;
      end
    end else if (phase == PH_TRANS) begin
      // latch the drive from the hall level and load the run timing
      pattern_a    = hall;
      half_period  = regs.initial_half_period;
      half_timer   = '0;
      second_half  = 1'b0;
      period_count = '0;
      phase        = PH_RUN;
    end else begin
      // start phase follows the hall level and counts its edges
      shown     = PH_START;
      pattern_a = hall;
      if (hall_seen && hall != prev_hall && edge_count < EDGE_COUNT_MAX)
        edge_count = edge_count + 16'd1;
      if (edge_count > regs.start_edge_limit) begin
        phase      = PH_TRANS;
        edge_count = '0;
      end else begin
        phase = PH_START;
      end
    end
    prev_hall = hall;
    hall_seen = 1'b1;
    item.gate_high_one = pattern_a;
    item.gate_low_one  = ~pattern_a;
    item.gate_high_two = ~pattern_a;
    item.gate_low_two  = pattern_a;
    item.phase_now     = shown;
    return item;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // compare one drive item against the oldest expectation
  task automatic check_gate_item();
    gate_item_t want;
    if (gate_queue.size() == 0) begin
      flag_mismatch("drive item with nothing expected");
      return;
    end
    want = gate_queue.pop_front();
    if (drive.gate_high_one !== want.gate_high_one)
      flag_mismatch($sformatf("gate_high_one got %b expected %b",
                              drive.gate_high_one, want.gate_high_one));
    if (drive.gate_low_one !== want.gate_low_one)
      flag_mismatch($sformatf("gate_low_one got %b expected %b",
                              drive.gate_low_one, want.gate_low_one));
    if (drive.gate_high_two !== want.gate_high_two)
      flag_mismatch($sformatf("gate_high_two got %b expected %b",
                              drive.gate_high_two, want.gate_high_two));
    if (drive.gate_low_two !== want.gate_low_two)
      flag_mismatch($sformatf("gate_low_two got %b expected %b",
                              drive.gate_low_two, want.gate_low_two));
    if (drive.phase_now !== want.phase_now)
      flag_mismatch($sformatf("phase_now got %0d expected %0d",
                              drive.phase_now, want.phase_now));
  endtask

  // watch both channels and the register port on every edge
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (drive.valid && drive.ready) begin
        check_gate_item();
        results_seen++;
      end
      if (samples.valid && samples.ready)
        gate_queue.push_back(commutate_tick(samples.hall_level));
      if (psel && penable && pwrite && pready)
        load_register(paddr[ADDR_W-1:2], pwdata);
    end
    outstanding <= gate_queue.size();
  end

endmodule

`default_nettype wire

// ----- test/single_phase_fan_commutation_ramp_tb.sv -----
`default_nettype none

module single_phase_fan_commutation_ramp_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfcr_pkg::*;

  // index with no register behind it
  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  // opening hall pattern, sent from the top bit down
  localparam logic [15:0] OPENING_HALL = 16'b1100_1011_0001_1101;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int outstanding;
  int results_seen;
  int ticks_sent;
  int writes_done;
  int tx_idle;
  int rx_idle;

  sfcr_in_if  samples ();
  sfcr_out_if drive ();

  single_phase_fan_commutation_ramp i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .drive   (drive),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sfcr_commutation_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .samples      (samples),
    .drive        (drive),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  always #5 clk = ~clk;

  // receiver stalls at random
  always @(posedge clk) begin
    drive.ready <= ($urandom_range(99) >= rx_idle);
  end

  // overall limit on the run
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle = tx_pct;
    rx_idle = rx_pct;
  endtask

  // offer one hall item, with random gaps, and wait until it is taken
  task automatic send_sample(input logic hall);
    while ($urandom_range(99) < tx_idle) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid      <= 1'b1;
    samples.hall_level <= hall;
    do @(posedge clk); while (!samples.ready);
    ticks_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(1'($urandom_range(1)));
  endtask

  // hold off until every gate item owed has come out
  task automatic drain();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    writes_done++;
  endtask

  initial begin
    rst                = 1'b1;
    samples.valid      = 1'b0;
    samples.hall_level = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    set_idling(19, 82);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // opening pattern at reset defaults, first sample high
    for (int k = 15; k >= 0; k--) send_sample(OPENING_HALL[k]);

    // hold the start phase for good and set up the run timing
    drain();
    write_reg(REG_START_EDGE_LIMIT, 32'd65535);
    write_reg(REG_INITIAL_HALF_PERIOD, 32'd65535);
    write_reg(REG_PERIODS_PER_STEP, 32'd1023);
    write_reg(REG_MIN_HALF_PERIOD, 32'd0);
    write_reg(REG_RAMP_STEP, {24'($urandom), 8'd1});
    write_reg(REG_UNMAPPED, $urandom);
    send_random(300);

    // a low limit is soon exceeded: transition into run
    drain();
    write_reg(REG_INITIAL_HALF_PERIOD, 32'd12);
    write_reg(REG_START_EDGE_LIMIT, 32'd30);
    send_random(200);

    // single tick steps every third period down to the minimum
    drain();
    set_idling(82, 19);
    write_reg(REG_PERIODS_PER_STEP, 32'd2);
    write_reg(REG_MIN_HALF_PERIOD, 32'd8);
    send_random(300);

    // step every period but by nothing
    drain();
    write_reg(REG_PERIODS_PER_STEP, {22'($urandom), 10'd0});
    write_reg(REG_RAMP_STEP, 32'd0);
    write_reg(REG_MIN_HALF_PERIOD, 32'd0);
    send_random(150);

    // last step lands below the minimum
    drain();
    set_idling(0, 0);
    write_reg(REG_RAMP_STEP, 32'd3);
    write_reg(REG_MIN_HALF_PERIOD, 32'd6);
    send_random(150);

    // minimum at its top: no ramp
    drain();
    write_reg(REG_MIN_HALF_PERIOD, 32'd65535);
    write_reg(REG_RAMP_STEP, 32'd255);
    write_reg(REG_INITIAL_HALF_PERIOD, 32'd1);
    send_random(150);

    // big step clamps the half period to zero: toggle every tick
    drain();
    write_reg(REG_MIN_HALF_PERIOD, 32'd0);
    write_reg(REG_START_EDGE_LIMIT, 32'd0);
    send_random(280);

    drain();
    repeat (4) @(posedge clk);

    $display("run: %0d hall items sent, %0d gate items checked, %0d register writes",
             ticks_sent, results_seen, writes_done);
    $display("run: start phase held then left, transition, ramp by one, by zero, %s",
             "below the minimum and down to a zero half period");
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- single_phase_fan_commutation_ramp.f -----
rtl/sfcr_pkg.sv
rtl/sfcr_if.sv
rtl/sfcr_regs.sv
rtl/single_phase_fan_commutation_ramp.sv
rtl/sfcr_checker.sv
test/sfcr_commutation_checker.sv
test/single_phase_fan_commutation_ramp_tb.sv
